// ===== rtl/core/cemcy_pkg.sv =====
// Shared types and constants for the CANopen emergency error manager.
// Used by cemcy_ctrl, cemcy_dp and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cemcy_pkg;

  localparam int MAX_ERRORS    = 8;
  localparam int HISTORY_DEPTH = 8;

  localparam int ERR_IDX_W  = (MAX_ERRORS > 1) ? $clog2(MAX_ERRORS) : 1;
  localparam int HIST_IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HIST_SIZE_W = 4;

  localparam logic [3:0] FRAME_LEN_SET     = 4'd5;
  localparam logic [3:0] FRAME_LEN_RECOVER = 4'd8;

  // configuration register indexes (byte address 4*i)
  localparam int          REG_IDX_W     = 2;
  localparam logic [1:0]  REG_EMCY_EN   = 2'd0;
  localparam logic [1:0]  REG_FRAME_ID  = 2'd1;
  localparam logic [1:0]  REG_HIST_SIZE = 2'd2;

  localparam logic        RST_EMCY_EN   = 1'b1;
  localparam logic [10:0] RST_FRAME_ID  = 11'd128;
  localparam logic [3:0]  RST_HIST_SIZE = 4'd8;

  typedef enum logic [1:0] {
    CMD_SET     = 2'd0,
    CMD_RECOVER = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_READ    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ALREADY    = 3'd0,
    ST_FULL       = 3'd1,
    ST_RECORDED   = 3'd2,
    ST_SENT       = 3'd3,
    ST_RECOVERED  = 3'd4,
    ST_NOT_ACTIVE = 3'd5,
    ST_DONE       = 3'd6
  } status_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] error_code;
    logic [7:0]  register_mask;
    logic [15:0] extra_info;
    logic [2:0]  read_index;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic        frame_valid;
    logic [10:0] frame_id;
    logic [3:0]  frame_length;
    logic [63:0] frame_payload;
    logic [7:0]  error_register_out;
    logic [3:0]  history_count;
    logic [31:0] history_word;
    logic        any_error;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic    capture;
    logic    scan_start;
    logic    scan_step;
    logic    entry_set;
    logic    entry_recover;
    logic    hist_push;
    logic    hist_clear;
    logic    gather_commit;
    logic    result_load;
    status_e status;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_e cmd;
    logic match_hit;
    logic match_active;
    logic free_hit;
    logic scan_last;
    logic rsp_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/cemcy_ctrl.sv =====
// Sequencer for the emergency error manager: search scan, decision,
// register gather scan and result hand-off. Depends on cemcy_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cemcy_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_ready,
  input  wire cemcy_pkg::dp_stat_t  stat,
  output cemcy_pkg::ctrl_cmd_t      ctl
);
  import cemcy_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_DECIDE = 5'b00100,
    S_GATHER = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t  state, state_next;
  status_e status_q, status_q_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      status_q <= ST_DONE;
    end else begin
      state    <= state_next;
      status_q <= status_q_next;
    end
  end

  always_comb begin
    ctl           = '0;
    ctl.status    = status_q;
    cmd_ready     = 1'b0;
    state_next    = state;
    status_q_next = status_q;
    case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          ctl.capture    = 1'b1;
          ctl.scan_start = 1'b1;
          state_next     = S_SEARCH;
        end
      end
      S_SEARCH: begin
        ctl.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_FINISH;
        case (stat.cmd)
          CMD_SET: begin
            if (stat.match_hit && stat.match_active) begin
              status_q_next = ST_ALREADY;
            end else if (stat.match_hit || stat.free_hit) begin
              ctl.entry_set  = 1'b1;
              ctl.hist_push  = 1'b1;
              ctl.scan_start = 1'b1;
              status_q_next  = ST_RECORDED;
              state_next     = S_GATHER;
            end else begin
              status_q_next = ST_FULL;
            end
          end
          CMD_RECOVER: begin
            if (stat.match_hit && stat.match_active) begin
              ctl.entry_recover = 1'b1;
              ctl.scan_start    = 1'b1;
              status_q_next     = ST_RECOVERED;
              state_next        = S_GATHER;
            end else begin
              status_q_next = ST_NOT_ACTIVE;
            end
          end
          CMD_CLEAR: begin
            ctl.hist_clear = 1'b1;
            status_q_next  = ST_DONE;
          end
          default: begin
            status_q_next = ST_DONE;
          end
        endcase
      end
      S_GATHER: begin
        ctl.scan_step = 1'b1;
        if (stat.scan_last) begin
          ctl.gather_commit = 1'b1;
          state_next        = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!stat.rsp_busy) begin
          ctl.result_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/cemcy_dp.sv =====
// Datapath of the emergency error manager: error table, scan unit,
// history shift line, error register and the result register. Depends on cemcy_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cemcy_dp (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cemcy_pkg::in_item_t   cmd_item,
  input  wire cemcy_pkg::ctrl_cmd_t  ctl,
  output cemcy_pkg::dp_stat_t        stat,
  input  wire logic                  emergency_enabled,
  input  wire logic [10:0]           frame_identifier,
  input  wire logic [3:0]            history_size,
  input  wire logic                  rsp_ready,
  output logic                       rsp_valid,
  output cemcy_pkg::out_item_t       rsp_item
);
  import cemcy_pkg::*;

  in_item_t item;

  // error table
  logic [15:0]           entry_code   [MAX_ERRORS];
  logic [7:0]            entry_mask   [MAX_ERRORS];
  logic [MAX_ERRORS-1:0] entry_active;

  // scan unit
  logic [ERR_IDX_W-1:0] idx;
  logic                 match_hit, match_active, free_hit;
  logic [ERR_IDX_W-1:0] match_idx, free_idx;
  logic [7:0]           acc;
  logic                 any;

  logic [31:0]            history [HISTORY_DEPTH];
  logic [3:0]             hist_count;
  logic [7:0]             err_reg;
  logic                   err_seen;

  logic                   code_eq, cur_active, any_next, scan_last;
  logic [7:0]             acc_next;
  logic [ERR_IDX_W-1:0]   slot;
  logic [HIST_SIZE_W-1:0] size_use;
  logic                   ridx_ok;
  logic [HIST_IDX_W-1:0]  hidx;
  out_item_t              rsp_next;

  assign code_eq    = (entry_code[idx] == item.error_code);
  assign cur_active = entry_active[idx];
  assign acc_next   = acc | (cur_active ? entry_mask[idx] : 8'h00);
  assign any_next   = any | cur_active;
  assign scan_last  = (idx == ERR_IDX_W'(MAX_ERRORS - 1));
  assign slot       = match_hit ? match_idx : free_idx;
  assign ridx_ok    = (int'(item.read_index) < HISTORY_DEPTH);
  assign hidx       = HIST_IDX_W'(item.read_index);

  always_comb begin
    if (history_size == '0) begin
      size_use = HIST_SIZE_W'(1);
    end else if (int'(history_size) > HISTORY_DEPTH) begin
      size_use = HIST_SIZE_W'(HISTORY_DEPTH);
    end else begin
      size_use = history_size;
    end
  end

  always_comb begin
    stat.cmd          = item.cmd;
    stat.match_hit    = match_hit;
    stat.match_active = match_active;
    stat.free_hit     = free_hit;
    stat.scan_last    = scan_last;
    stat.rsp_busy     = rsp_valid & ~rsp_ready;
  end

  // capture and scan
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item <= cmd_item;
    end
    if (ctl.scan_start) begin
      idx       <= '0;
      match_hit <= 1'b0;
      free_hit  <= 1'b0;
      acc       <= '0;
      any       <= 1'b0;
    end else if (ctl.scan_step) begin
      idx <= idx + ERR_IDX_W'(1);
      // keep the first code hit and the first free entry
      if (code_eq && !match_hit) begin
        match_hit    <= 1'b1;
        match_active <= cur_active;
        match_idx    <= idx;
      end
      if (!cur_active && !free_hit) begin
        free_hit <= 1'b1;
        free_idx <= idx;
      end
      acc <= acc_next;
      any <= any_next;
    end
  end

  // error table, error register and history
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_ERRORS; i++) begin
        entry_code[i] <= '0;
        entry_mask[i] <= '0;
      end
      entry_active <= '0;
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        history[k] <= '0;
      end
      hist_count <= '0;
      err_reg    <= '0;
      err_seen   <= 1'b0;
    end else begin
      if (ctl.entry_set) begin
        entry_code[slot]   <= item.error_code;
        entry_mask[slot]   <= item.register_mask;
        entry_active[slot] <= 1'b1;
      end else if (ctl.entry_recover) begin
        entry_active[match_idx] <= 1'b0;
      end
      if (ctl.gather_commit) begin
        err_reg  <= acc_next;
        err_seen <= any_next;
      end
      if (ctl.hist_clear) begin
        for (int k = 0; k < HISTORY_DEPTH; k++) begin
          history[k] <= '0;
        end
        hist_count <= '0;
      end else if (ctl.hist_push) begin
        // shift only the part of the history in use
        for (int k = 1; k < HISTORY_DEPTH; k++) begin
          if (k < int'(size_use)) begin
            history[k] <= history[k-1];
          end
        end
        history[0] <= {item.extra_info, item.error_code};
        if (hist_count < size_use) begin
          hist_count <= hist_count + 4'd1;
        end
      end
    end
  end

  always_comb begin
    rsp_next                    = '0;
    rsp_next.status             = ctl.status;
    rsp_next.error_register_out = err_reg;
    rsp_next.history_count      = hist_count;
    rsp_next.any_error          = err_seen;
    if (ctl.status == ST_RECORDED && emergency_enabled) begin
      rsp_next.status        = ST_SENT;
      rsp_next.frame_valid   = 1'b1;
      rsp_next.frame_id      = frame_identifier;
      rsp_next.frame_length  = FRAME_LEN_SET;
      rsp_next.frame_payload = {24'd0, item.extra_info[7:0], 8'd0, err_reg,
                                item.error_code};
    end
    // last active error gone: all-zero frame
    if (ctl.status == ST_RECOVERED && !err_seen && emergency_enabled) begin
      rsp_next.frame_valid  = 1'b1;
      rsp_next.frame_id     = frame_identifier;
      rsp_next.frame_length = FRAME_LEN_RECOVER;
    end
    if (item.cmd == CMD_READ && ridx_ok) begin
      rsp_next.history_word = history[hidx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.result_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.result_load) begin
      rsp_item <= rsp_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/canopen_emergency_error_manager.sv =====
// CANopen emergency error manager. Each command transaction yields exactly one
// response transaction. A command first scans the error table one entry per
// cycle; a set or recover that changes the table then scans it again to rebuild
// the error register. One command is in work at a time; the response sits in an
// output register, so the next command is taken while the previous response
// waits, and that command holds in its finishing state until the waiting
// response is taken. Registers sit on an APB port at 0x0 (emergency enable),
// 0x4 (CAN identifier) and 0x8 (history size); the user must see that they are
// written only while no command is in work, as the block does not enforce it.
// Depends on cemcy_pkg, cemcy_ctrl and cemcy_dp.
`timescale 1ns / 1ps
`default_nettype none

module canopen_emergency_error_manager (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_ready,
  input  wire cemcy_pkg::in_item_t  cmd_item,
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  output cemcy_pkg::out_item_t      rsp_item,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [3:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import cemcy_pkg::*;

  logic                 emergency_enabled;
  logic [10:0]          frame_identifier;
  logic [3:0]           history_size;
  logic                 reg_write;
  logic [REG_IDX_W-1:0] reg_idx;
  ctrl_cmd_t            ctl;
  dp_stat_t             stat;

  assign pready    = 1'b1;
  assign reg_write = psel & penable & pwrite;
  assign reg_idx   = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      emergency_enabled <= RST_EMCY_EN;
      frame_identifier  <= RST_FRAME_ID;
      history_size      <= RST_HIST_SIZE;
    end else if (reg_write) begin
      case (reg_idx)
        REG_EMCY_EN:   emergency_enabled <= pwdata[0];
        REG_FRAME_ID:  frame_identifier  <= pwdata[10:0];
        REG_HIST_SIZE: history_size      <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_EMCY_EN:   prdata = {31'd0, emergency_enabled};
      REG_FRAME_ID:  prdata = {21'd0, frame_identifier};
      REG_HIST_SIZE: prdata = {28'd0, history_size};
      default:       prdata = '0;
    endcase
  end

  cemcy_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  cemcy_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd_item          (cmd_item),
    .ctl               (ctl),
    .stat              (stat),
    .emergency_enabled (emergency_enabled),
    .frame_identifier  (frame_identifier),
    .history_size      (history_size),
    .rsp_ready         (rsp_ready),
    .rsp_valid         (rsp_valid),
    .rsp_item          (rsp_item)
  );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for canopen_emergency_error_manager: directed table, then random
// phases under several register settings, each response checked against an in-bench model
// or a table row. Depends on cemcy_pkg and the canopen_emergency_error_manager RTL.
`timescale 1ns / 1ps

module tb_top;
  import cemcy_pkg::*;

  localparam int DIR_ROWS    = 23;
  localparam int NUM_PHASES  = 6;
  localparam int SETTLE_CYC  = 2 * MAX_ERRORS + 8;
  localparam int LONG_HOLD   = 400;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t rsp;
  } drow_t;

  logic        clk;
  logic        rst;
  logic        cmd_valid;
  logic        cmd_ready;
  in_item_t    cmd_item;
  logic        rsp_valid;
  logic        rsp_ready;
  out_item_t   rsp_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  canopen_emergency_error_manager u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_item  (cmd_item),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_item  (rsp_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Error table / history model
  // ---------------------------------------------------------------------------
  logic [15:0] tbl_code   [MAX_ERRORS];
  logic [7:0]  tbl_mask   [MAX_ERRORS];
  logic        tbl_active [MAX_ERRORS];
  logic [31:0] hist_words [HISTORY_DEPTH];
  logic [3:0]  hist_count;
  logic [7:0]  err_reg;
  logic        err_occurred;
  logic        cfg_emcy_en;
  logic [10:0] cfg_frame_id;
  logic [3:0]  cfg_hist_size;

  out_item_t   emcy_rsp_q [$];
  int          fail_cnt;
  int unsigned cycle_cnt;
  logic        idle_on;
  logic        long_hold_req;
  out_item_t   rsp_want;
  string       rsp_diffs;
  drow_t       dir_tab [DIR_ROWS];

  task automatic model_reset();
    int i;
    for (i = 0; i < MAX_ERRORS; i++) begin
      tbl_code[i]   = '0;
      tbl_mask[i]   = '0;
      tbl_active[i] = 1'b0;
    end
    for (i = 0; i < HISTORY_DEPTH; i++) hist_words[i] = '0;
    hist_count    = '0;
    err_reg       = '0;
    err_occurred  = 1'b0;
    cfg_emcy_en   = RST_EMCY_EN;
    cfg_frame_id  = RST_FRAME_ID;
    cfg_hist_size = RST_HIST_SIZE;
  endtask

  function automatic logic [7:0] active_mask_or();
    logic [7:0] acc;
    int i;
    acc = '0;
    for (i = 0; i < MAX_ERRORS; i++)
      if (tbl_active[i]) acc = acc | tbl_mask[i];
    return acc;
  endfunction

  // Apply one command to the model and return the response it produces.
  function automatic out_item_t emcy_step(in_item_t it);
    out_item_t r;
    int slot;
    int sz;
    int i;
    logic dropped;
    logic still_active;
    r = '0;
    r.status = ST_DONE;
    case (it.cmd)
      CMD_SET: begin
        slot = -1;
        dropped = 1'b0;
        for (i = 0; i < MAX_ERRORS; i++)
          if (slot < 0 && tbl_code[i] == it.error_code) begin
            slot = i;
            dropped = tbl_active[i];
          end
        if (dropped) begin
          r.status = ST_ALREADY;
        end else begin
          if (slot < 0)
            for (i = 0; i < MAX_ERRORS; i++)
              if (slot < 0 && !tbl_active[i]) slot = i;
          if (slot < 0) begin
            r.status = ST_FULL;
          end else begin
            // clamp the history size in use to 1..HISTORY_DEPTH
            sz = (cfg_hist_size == 0) ? 1 :
                 (cfg_hist_size > HISTORY_DEPTH) ? HISTORY_DEPTH : int'(cfg_hist_size);
            tbl_code[slot]   = it.error_code;
            tbl_mask[slot]   = it.register_mask;
            tbl_active[slot] = 1'b1;
            err_occurred     = 1'b1;
            err_reg          = active_mask_or();
            for (i = sz - 1; i > 0; i--) hist_words[i] = hist_words[i - 1];
            hist_words[0] = {it.extra_info, it.error_code};
            if (hist_count < sz) hist_count = hist_count + 4'd1;
            if (cfg_emcy_en) begin
              r.status        = ST_SENT;
              r.frame_valid   = 1'b1;
              r.frame_length  = FRAME_LEN_SET;
              r.frame_payload = {24'd0, it.extra_info[7:0], 8'd0, err_reg, it.error_code};
            end else begin
              r.status = ST_RECORDED;
            end
          end
        end
      end
      CMD_RECOVER: begin
        slot = -1;
        for (i = 0; i < MAX_ERRORS; i++)
          if (slot < 0 && tbl_code[i] == it.error_code) slot = i;
        if (slot >= 0 && tbl_active[slot]) begin
          tbl_active[slot] = 1'b0;
          err_reg  = active_mask_or();
          r.status = ST_RECOVERED;
          still_active = 1'b0;
          for (i = 0; i < MAX_ERRORS; i++) still_active = still_active | tbl_active[i];
          if (!still_active) begin
            err_occurred = 1'b0;
            if (cfg_emcy_en) begin
              r.frame_valid  = 1'b1;
              r.frame_length = FRAME_LEN_RECOVER;
            end
          end
        end else begin
          r.status = ST_NOT_ACTIVE;
        end
      end
      CMD_CLEAR: begin
        for (i = 0; i < HISTORY_DEPTH; i++) hist_words[i] = '0;
        hist_count = '0;
      end
      default: begin
        if (it.read_index < HISTORY_DEPTH) r.history_word = hist_words[it.read_index];
      end
    endcase
    r.frame_id           = r.frame_valid ? cfg_frame_id : 11'd0;
    r.error_register_out = err_reg;
    r.history_count      = hist_count;
    r.any_error          = err_occurred;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_item_t mk_cmd(cmd_e c, logic [15:0] code, logic [7:0] mask,
                                      logic [15:0] info, logic [2:0] idx);
    in_item_t it;
    it.cmd           = c;
    it.error_code    = code;
    it.register_mask = mask;
    it.extra_info    = info;
    it.read_index    = idx;
    return it;
  endfunction

  function automatic out_item_t mk_rsp(status_e st, logic fv, logic [10:0] fid,
                                       logic [3:0] flen, logic [63:0] pay, logic [7:0] ereg,
                                       logic [3:0] cnt, logic [31:0] hword, logic any);
    out_item_t r;
    r.status             = st;
    r.frame_valid        = fv;
    r.frame_id           = fid;
    r.frame_length       = flen;
    r.frame_payload      = pay;
    r.error_register_out = ereg;
    r.history_count      = cnt;
    r.history_word       = hword;
    r.any_error          = any;
    return r;
  endfunction

  function automatic drow_t row(in_item_t it);
    drow_t d;
    d.item  = it;
    d.typed = 1'b0;
    d.rsp   = '0;
    return d;
  endfunction

  function automatic drow_t trow(in_item_t it, out_item_t rsp);
    drow_t d;
    d.item  = it;
    d.typed = 1'b1;
    d.rsp   = rsp;
    return d;
  endfunction

  // small pool of codes so that sets and recovers hit the same entries
  function automatic logic [15:0] pool_code(int k);
    case (k)
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h1000;
      3:       return 16'h2310;
      4:       return 16'h3210;
      5:       return 16'h4200;
      6:       return 16'h5000;
      7:       return 16'h6100;
      8:       return 16'h7000;
      9:       return 16'h8110;
      10:      return 16'h9000;
      default: return 16'hFF00;
    endcase
  endfunction

  function automatic in_item_t rand_cmd(int set_pct);
    in_item_t it;
    int r;
    it.error_code    = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                       pool_code($urandom_range(0, 11));
    it.register_mask = 8'($urandom);
    it.extra_info    = 16'($urandom);
    it.read_index    = 3'($urandom);
    r = $urandom_range(0, 99);
    if (r < set_pct) begin
      it.cmd = CMD_SET;
    end else begin
      r = $urandom_range(0, 99);
      it.cmd = (r < 70) ? CMD_RECOVER : (r < 92) ? CMD_READ : CMD_CLEAR;
    end
    return it;
  endfunction

  task automatic note_failure(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%s", msg);
  endtask

  // Offer one command; hold valid and payload until the transaction is taken.
  task automatic send_cmd(in_item_t it, logic typed, out_item_t typed_rsp);
    out_item_t p;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    cmd_item  <= it;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
    p = emcy_step(it);
    emcy_rsp_q.push_back(typed ? typed_rsp : p);
  endtask

  // Drain all responses, then give the block time to go idle.
  task automatic settle();
    cmd_valid <= 1'b0;
    while (emcy_rsp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_EMCY_EN:   cfg_emcy_en   = val[0];
      REG_FRAME_ID:  cfg_frame_id  = val[10:0];
      REG_HIST_SIZE: cfg_hist_size = val[3:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------
  initial begin : cmd_side
    int n;
    int p;
    int items;
    int set_pct;
    logic [31:0] en_val;
    logic [31:0] id_val;
    logic [31:0] hsz_val;
    rst           <= 1'b1;
    cmd_valid     <= 1'b0;
    cmd_item      <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    idle_on       = 1'b1;
    long_hold_req = 1'b0;
    fail_cnt      = 0;
    model_reset();

    dir_tab[0]  = trow(mk_cmd(CMD_READ, 16'h0000, 8'h00, 16'h0000, 3'd0),
                       mk_rsp(ST_DONE, 1'b0, 11'd0, 4'd0, 64'd0, 8'h00, 4'd0, 32'd0, 1'b0));
    dir_tab[1]  = trow(mk_cmd(CMD_RECOVER, 16'h1234, 8'hFF, 16'hFFFF, 3'd7),
                       mk_rsp(ST_NOT_ACTIVE, 1'b0, 11'd0, 4'd0, 64'd0, 8'h00, 4'd0, 32'd0,
                              1'b0));
    dir_tab[2]  = trow(mk_cmd(CMD_CLEAR, 16'hFFFF, 8'h00, 16'h0000, 3'd0),
                       mk_rsp(ST_DONE, 1'b0, 11'd0, 4'd0, 64'd0, 8'h00, 4'd0, 32'd0, 1'b0));
    // code zero matches a freshly reset entry and reuses it
    dir_tab[3]  = trow(mk_cmd(CMD_SET, 16'h0000, 8'hFF, 16'hFFFF, 3'd7),
                       mk_rsp(ST_SENT, 1'b1, RST_FRAME_ID, FRAME_LEN_SET,
                              64'h0000_00FF_00FF_0000, 8'hFF, 4'd1, 32'd0, 1'b1));
    dir_tab[4]  = trow(mk_cmd(CMD_SET, 16'h0000, 8'h00, 16'h0000, 3'd0),
                       mk_rsp(ST_ALREADY, 1'b0, 11'd0, 4'd0, 64'd0, 8'hFF, 4'd1, 32'd0,
                              1'b1));
    dir_tab[5]  = row(mk_cmd(CMD_SET, 16'hFFFF, 8'h01, 16'h0000, 3'd0));
    dir_tab[6]  = row(mk_cmd(CMD_RECOVER, 16'h0000, 8'h00, 16'h0000, 3'd0));
    // last active entry goes away: all-zero frame
    dir_tab[7]  = row(mk_cmd(CMD_RECOVER, 16'hFFFF, 8'h00, 16'h0000, 3'd0));
    for (n = 0; n < MAX_ERRORS; n++)
      dir_tab[8 + n] = row(mk_cmd(CMD_SET, 16'h1001 + 16'(n), 8'(1 << n),
                                  16'h5A00 | 16'(n), 3'(n)));
    dir_tab[16] = row(mk_cmd(CMD_SET, 16'h2000, 8'hFF, 16'hFFFF, 3'd0));
    dir_tab[17] = row(mk_cmd(CMD_READ, 16'h0000, 8'h00, 16'h0000, 3'd7));
    dir_tab[18] = row(mk_cmd(CMD_READ, 16'hFFFF, 8'hFF, 16'hFFFF, 3'd0));
    dir_tab[19] = row(mk_cmd(CMD_RECOVER, 16'h1001, 8'h00, 16'h0000, 3'd0));
    dir_tab[20] = row(mk_cmd(CMD_SET, 16'h1001, 8'hFF, 16'h00FF, 3'd0));
    dir_tab[21] = row(mk_cmd(CMD_CLEAR, 16'h0000, 8'h00, 16'h0000, 3'd0));
    dir_tab[22] = row(mk_cmd(CMD_READ, 16'h0000, 8'h00, 16'h0000, 3'd0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (n = 0; n < DIR_ROWS; n++)
      send_cmd(dir_tab[n].item, dir_tab[n].typed, dir_tab[n].rsp);

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       begin en_val = 1; id_val = 32'h7FF; hsz_val = 8;  items = 250; set_pct = 45; end
        1:       begin en_val = 0; id_val = 32'h000; hsz_val = 1;  items = 200; set_pct = 60; end
        2:       begin en_val = 1; id_val = 32'h555; hsz_val = 0;  items = 200; set_pct = 40; end
        3:       begin en_val = 1; id_val = 32'h2AA; hsz_val = 15; items = 250; set_pct = 65; end
        4:       begin en_val = 0; id_val = 32'h001; hsz_val = 3;  items = 200; set_pct = 35; end
        default: begin en_val = 1; id_val = 32'h080; hsz_val = 8;  items = 300; set_pct = 50; end
      endcase
      settle();
      apb_write(REG_EMCY_EN, en_val);
      apb_write(REG_FRAME_ID, id_val);
      apb_write(REG_HIST_SIZE, hsz_val);
      idle_on = (p != NUM_PHASES - 1);
      if (p == 0) long_hold_req = 1'b1;
      for (n = 0; n < items; n++) send_cmd(rand_cmd(set_pct), 1'b0, '0);
    end

    settle();
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Response side: random stalls, plus one long hold-off to back up the block
  // ---------------------------------------------------------------------------
  initial begin : rsp_side
    int gap;
    rsp_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rsp_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 10);
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        rsp_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic string rsp_diff(out_item_t w, out_item_t g);
    string s;
    s = "";
    if (g.status !== w.status)
      s = {s, $sformatf(" status %0d/%0d", w.status, g.status)};
    if (g.frame_valid !== w.frame_valid)
      s = {s, $sformatf(" frame_valid %0b/%0b", w.frame_valid, g.frame_valid)};
    if (g.frame_id !== w.frame_id)
      s = {s, $sformatf(" frame_id %h/%h", w.frame_id, g.frame_id)};
    if (g.frame_length !== w.frame_length)
      s = {s, $sformatf(" frame_length %0d/%0d", w.frame_length, g.frame_length)};
    if (g.frame_payload !== w.frame_payload)
      s = {s, $sformatf(" frame_payload %h/%h", w.frame_payload, g.frame_payload)};
    if (g.error_register_out !== w.error_register_out)
      s = {s, $sformatf(" error_register_out %h/%h", w.error_register_out,
                        g.error_register_out)};
    if (g.history_count !== w.history_count)
      s = {s, $sformatf(" history_count %0d/%0d", w.history_count, g.history_count)};
    if (g.history_word !== w.history_word)
      s = {s, $sformatf(" history_word %h/%h", w.history_word, g.history_word)};
    if (g.any_error !== w.any_error)
      s = {s, $sformatf(" any_error %0b/%0b", w.any_error, g.any_error)};
    return s;
  endfunction

  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_ready) begin
      if (emcy_rsp_q.size() == 0) begin
        note_failure($sformatf("unexpected response transaction at cycle %0d", cycle_cnt));
      end else begin
        rsp_want  = emcy_rsp_q.pop_front();
        rsp_diffs = rsp_diff(rsp_want, rsp_item);
        if (rsp_diffs != "")
          note_failure($sformatf("response mismatch at cycle %0d (want/got):%s",
                                 cycle_cnt, rsp_diffs));
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      cycle_cnt <= 0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d responses outstanding",
                 cycle_cnt, emcy_rsp_q.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule

// ===== sim.f =====
rtl/core/cemcy_pkg.sv
rtl/core/cemcy_ctrl.sv
rtl/core/cemcy_dp.sv
rtl/core/canopen_emergency_error_manager.sv
tb/tb_top.sv
